FILE: src/tbte_pkg.sv
package tbte_pkg;

    localparam int NUM_TIMERS = 16;
    // slot fields are four bits wide, so at most sixteen slots are used
    localparam int BANK_SLOTS = (NUM_TIMERS < 16) ? NUM_TIMERS : 16;

    localparam int REQ_W   = 2;
    localparam int DELTA_W = 20;
    localparam int TIME_W  = 32;
    localparam int SLOT_W  = 4;
    localparam int KIND_W  = 2;

    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_START = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    localparam logic [KIND_W-1:0] EV_FIRE      = 2'd0;
    localparam logic [KIND_W-1:0] EV_TICK_DONE = 2'd1;
    localparam logic [KIND_W-1:0] EV_START     = 2'd2;
    localparam logic [KIND_W-1:0] EV_CLEAR     = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [DELTA_W-1:0] delta_us;
        logic [TIME_W-1:0]  period_us;
        logic               periodic;
        logic [SLOT_W-1:0]  slot_sel;
    } req_t;

    typedef struct packed {
        logic               valid;
        logic [KIND_W-1:0]  kind;
        logic [SLOT_W-1:0]  slot;
        logic               status;
        logic               last;
    } emit_t;

endpackage

FILE: src/tbte_if.sv
interface tbte_req_if
    import tbte_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [DELTA_W-1:0] delta_us;
    logic [TIME_W-1:0]  period_us;
    logic               periodic;
    logic [SLOT_W-1:0]  slot_sel;

    modport source (output valid, req_type, delta_us, period_us, periodic, slot_sel,
                    input ready);
    modport sink (input valid, req_type, delta_us, period_us, periodic, slot_sel,
                  output ready);
endinterface

interface tbte_evt_if
    import tbte_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] event_kind;
    logic [SLOT_W-1:0] slot_id;
    logic              status;
    logic              last;

    modport source (output valid, event_kind, slot_id, status, last, input ready);
    modport sink (input valid, event_kind, slot_id, status, last, output ready);
endinterface

FILE: src/timer_bank_tick_engine.sv
// channel  dir  payload                                        transfer
// req      in   req_type delta_us period_us periodic slot_sel  valid && ready
// evt      out  event_kind slot_id status last                 valid && ready
//
// a tick takes the request, then passes each slot in turn through the
// shared saturating adder and compare, then gives the tick-done result
// start and clear each give one result; a request of code 3 gives nothing
// req.ready is high only between requests; results wait in a one-entry output
// register, and a full register holds the scan on the slot that fires
// rst_n clears live and expired marks; slot durations and counts need no reset
module timer_bank_tick_engine
    import tbte_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    tbte_req_if.sink      req,
    tbte_evt_if.source    evt
);

    req_t              in_req;
    emit_t             emit;
    logic              can_emit;
    logic              out_valid_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              status_reg;
    logic              last_reg;

    assign in_req.req_type  = req.req_type;
    assign in_req.delta_us  = req.delta_us;
    assign in_req.period_us = req.period_us;
    assign in_req.periodic  = req.periodic;
    assign in_req.slot_sel  = req.slot_sel;

    assign can_emit = !out_valid_reg || evt.ready;

    tbte_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .in_req   (in_req),
        .can_emit (can_emit),
        .emit     (emit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit.valid)
            out_valid_reg <= 1'b1;
        else if (evt.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            kind_reg   <= emit.kind;
            slot_reg   <= emit.slot;
            status_reg <= emit.status;
            last_reg   <= emit.last;
        end
    end

    assign evt.valid      = out_valid_reg;
    assign evt.event_kind = kind_reg;
    assign evt.slot_id    = slot_reg;
    assign evt.status     = status_reg;
    assign evt.last       = last_reg;

endmodule

FILE: src/tbte_tick_alu.sv
module tbte_tick_alu
    import tbte_pkg::*;
(
    input  logic [TIME_W-1:0]  count,
    input  logic [DELTA_W-1:0] delta,
    input  logic [TIME_W-1:0]  period,
    output logic [TIME_W-1:0]  sum,
    output logic               reached
);

    logic [TIME_W:0] wide_sum;

    assign wide_sum = {1'b0, count} + (TIME_W+1)'(delta);
    // saturate at all ones on carry out
    assign sum      = wide_sum[TIME_W] ? {TIME_W{1'b1}} : wide_sum[TIME_W-1:0];
    assign reached  = (sum >= period);

endmodule

FILE: src/tbte_ctrl.sv
module tbte_ctrl
    import tbte_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  req_t  in_req,
    input  logic  can_emit,
    output emit_t emit
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_TICK  = 3'd1;
    localparam logic [2:0] ST_TDONE = 3'd2;
    localparam logic [2:0] ST_START = 3'd3;
    localparam logic [2:0] ST_CLEAR = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [SLOT_W-1:0]     idx_reg, idx_next;
    req_t                  req_reg;
    logic [BANK_SLOTS-1:0] active_reg, active_next;
    logic [BANK_SLOTS-1:0] done_reg, done_next;

    logic                  repeat_mem [BANK_SLOTS];
    logic [TIME_W-1:0]     period_mem [BANK_SLOTS];
    logic [TIME_W-1:0]     count_mem  [BANK_SLOTS];

    logic                  repeat_rd_reg;
    logic [TIME_W-1:0]     period_rd_reg;
    logic [TIME_W-1:0]     count_rd_reg;

    logic                  cnt_we;
    logic [SLOT_W-1:0]     cnt_wa;
    logic [TIME_W-1:0]     cnt_wd;
    logic                  new_we;

    logic [TIME_W-1:0]     sum;
    logic                  reached;
    logic                  last_idx;
    logic                  free_found;
    logic [SLOT_W-1:0]     free_idx;
    logic                  sel_ok;

    tbte_tick_alu u_alu (
        .count   (count_rd_reg),
        .delta   (req_reg.delta_us),
        .period  (period_rd_reg),
        .sum     (sum),
        .reached (reached)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign last_idx = (idx_reg == SLOT_W'(BANK_SLOTS - 1));
    assign sel_ok   = (32'(req_reg.slot_sel) < BANK_SLOTS) && active_reg[req_reg.slot_sel];

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = BANK_SLOTS - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        active_next = active_reg;
        done_next   = done_reg;
        cnt_we      = 1'b0;
        cnt_wa      = idx_reg;
        cnt_wd      = sum;
        new_we      = 1'b0;
        emit        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (in_valid)
                begin
                    case (in_req.req_type)
                        REQ_TICK:  state_next = ST_TICK;
                        REQ_START: state_next = ST_START;
                        REQ_CLEAR: state_next = ST_CLEAR;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_TICK:
            begin
                if (!active_reg[idx_reg])
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = last_idx ? ST_TDONE : ST_TICK;
                end
                else if (done_reg[idx_reg])
                begin
                    active_next[idx_reg] = 1'b0;
                    done_next[idx_reg]   = 1'b0;
                    idx_next             = idx_reg + 1'b1;
                    state_next           = last_idx ? ST_TDONE : ST_TICK;
                end
                else if (!reached || can_emit)
                begin
                    // a firing slot holds here until the output stage is free
                    cnt_we = 1'b1;
                    if (reached)
                    begin
                        emit.valid  = 1'b1;
                        emit.kind   = EV_FIRE;
                        emit.slot   = idx_reg;
                        if (repeat_rd_reg)
                            cnt_wd = '0;
                        else
                            done_next[idx_reg] = 1'b1;
                    end
                    idx_next   = idx_reg + 1'b1;
                    state_next = last_idx ? ST_TDONE : ST_TICK;
                end
            end
            ST_TDONE:
            begin
                if (can_emit)
                begin
                    emit.valid = 1'b1;
                    emit.kind  = EV_TICK_DONE;
                    emit.last  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_START:
            begin
                if (can_emit)
                begin
                    emit.valid  = 1'b1;
                    emit.kind   = EV_START;
                    emit.last   = 1'b1;
                    emit.status = !free_found;
                    if (free_found)
                    begin
                        emit.slot             = free_idx;
                        active_next[free_idx] = 1'b1;
                        done_next[free_idx]   = 1'b0;
                        new_we                = 1'b1;
                        cnt_we                = 1'b1;
                        cnt_wa                = free_idx;
                        cnt_wd                = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_CLEAR:
            begin
                if (can_emit)
                begin
                    emit.valid  = 1'b1;
                    emit.kind   = EV_CLEAR;
                    emit.last   = 1'b1;
                    emit.slot   = req_reg.slot_sel;
                    emit.status = !sel_ok;
                    if (sel_ok)
                        done_next[req_reg.slot_sel] = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            idx_reg    <= '0;
            active_reg <= '0;
            done_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            active_reg <= active_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            req_reg <= in_req;
        if (cnt_we)
            count_mem[cnt_wa] <= cnt_wd;
        if (new_we)
        begin
            period_mem[free_idx] <= req_reg.period_us;
            repeat_mem[free_idx] <= req_reg.periodic;
        end
        // fetch the slot that the scan looks at next
        count_rd_reg  <= count_mem[idx_next];
        period_rd_reg <= period_mem[idx_next];
        repeat_rd_reg <= repeat_mem[idx_next];
    end

    a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit.valid |-> can_emit)
        else $error("result issued while output stage busy");

    a_idx_in_bank: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_TICK |-> 32'(idx_reg) < BANK_SLOTS)
        else $error("tick scan index beyond bank");

    a_start_marks_active: assert property (@(posedge clk) disable iff (!rst_n)
        emit.valid && emit.kind == EV_START && !emit.status
        |=> active_reg[$past(emit.slot)] && !done_reg[$past(emit.slot)])
        else $error("allocated slot not live");

    a_fire_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        emit.valid && emit.kind == EV_FIRE |-> !emit.last && !emit.status)
        else $error("fire event flagged as last or failed");

endmodule
